// ===== rtl/isrlu_pkg.sv =====
// Shared types and constants for the ISRLU activation block.
package isrlu_pkg;

	localparam int DATA_WIDTH_DEF = 16;
	localparam int ALPHA_W        = 16;
	localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd4096;
	localparam int MAG_BITS       = 16;
	localparam int ONE_SHIFT      = 28;
	localparam int RHS_SHIFT      = 30;

	typedef struct packed {
		logic vld;
		logic last;
		logic byp;
	} ctl_t;

endpackage

// ===== rtl/isrlu_pre.sv =====
// Front stages: magnitude, square, scaled square and initial remainder.
module isrlu_pre #(
	parameter int DATA_WIDTH = isrlu_pkg::DATA_WIDTH_DEF,
	parameter int WW = 2 * DATA_WIDTH + 50
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  isrlu_pkg::ctl_t                    ctl_in,
	input  logic signed [DATA_WIDTH-1:0]       x_in,
	input  logic [isrlu_pkg::ALPHA_W-1:0]      alpha,
	output isrlu_pkg::ctl_t                    ctl_out,
	output logic signed [DATA_WIDTH-1:0]       x_out,
	output logic [WW-1:0]                      e_out,
	output logic [WW-1:0]                      r_out
);
	import isrlu_pkg::*;

	localparam int SW = 2 * DATA_WIDTH;
	localparam int PW = DATA_WIDTH + ALPHA_W;

	ctl_t                          ctl_s1, ctl_s2, ctl_s3;
	logic signed [DATA_WIDTH-1:0]  x_s1, x_s2, x_s3;
	logic [DATA_WIDTH-1:0]         a;
	logic [SW-1:0]                 s_s1, s_s2;
	logic [PW-1:0]                 plo_s2, phi_s2;
	logic [WW-1:0]                 e_s3, r_s3;

	assign a = DATA_WIDTH'(~x_in) + DATA_WIDTH'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else if (en) begin
			ctl_s1 <= '{vld: ctl_in.vld, last: ctl_in.last,
				byp: ~x_in[DATA_WIDTH-1] || (alpha == '0)};
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1   <= x_in;
			s_s1   <= SW'(a) * SW'(a);
			x_s2   <= x_s1;
			s_s2   <= s_s1;
			plo_s2 <= PW'(alpha) * PW'(s_s1[DATA_WIDTH-1:0]);
			phi_s2 <= PW'(alpha) * PW'(s_s1[SW-1:DATA_WIDTH]);
			x_s3   <= x_s2;
			e_s3   <= (WW'(phi_s2) << DATA_WIDTH) + WW'(plo_s2)
				+ (WW'(1) << ONE_SHIFT);
			r_s3   <= WW'(s_s2) << RHS_SHIFT;
		end
	end

	assign ctl_out = ctl_s3;
	assign x_out   = x_s3;
	assign e_out   = e_s3;
	assign r_out   = r_s3;
endmodule

// ===== rtl/isrlu_cell.sv =====
// One restoring square-root cell: decides one bit of the magnitude.
module isrlu_cell #(
	parameter int DATA_WIDTH = isrlu_pkg::DATA_WIDTH_DEF,
	parameter int WW = 2 * DATA_WIDTH + 50,
	parameter int BIT = 0
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  isrlu_pkg::ctl_t                    ctl_in,
	input  logic signed [DATA_WIDTH-1:0]       x_in,
	input  logic [WW-1:0]                      e_in,
	input  logic [WW-1:0]                      r_in,
	input  logic [WW-1:0]                      em_in,
	input  logic [isrlu_pkg::MAG_BITS-1:0]     m_in,
	output isrlu_pkg::ctl_t                    ctl_out,
	output logic signed [DATA_WIDTH-1:0]       x_out,
	output logic [WW-1:0]                      e_out,
	output logic [WW-1:0]                      r_out,
	output logic [WW-1:0]                      em_out,
	output logic [isrlu_pkg::MAG_BITS-1:0]     m_out
);
	import isrlu_pkg::*;

	ctl_t                          ctl_q;
	logic signed [DATA_WIDTH-1:0]  x_q;
	logic [WW-1:0]                 e_q, r_q, em_q, trial;
	logic [MAG_BITS-1:0]           m_q;
	logic                          take;

	// E*(m+2^b)^2 - E*m^2 = (E*m)<<(b+1) + E<<(2b)
	assign trial = (em_in << (BIT + 1)) + (e_in << (2 * BIT));
	assign take  = (trial <= r_in);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ctl_q <= '0;
		else if (en)
			ctl_q <= ctl_in;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_q  <= x_in;
			e_q  <= e_in;
			r_q  <= take ? r_in - trial : r_in;
			em_q <= take ? em_in + (e_in << BIT) : em_in;
			m_q  <= m_in | (MAG_BITS'(take) << BIT);
		end
	end

	assign ctl_out = ctl_q;
	assign x_out   = x_q;
	assign e_out   = e_q;
	assign r_out   = r_q;
	assign em_out  = em_q;
	assign m_out   = m_q;
endmodule

// ===== rtl/isrlu_activation.sv =====
// Top level of the ISRLU activation block: config register, cell chain, output stage.
//  channel | signals                          | dir
//  in      | in_valid in_ready x last_in      | sink
//  out     | out_valid out_ready y last_out   | source
//  cfg     | cfg_valid cfg_ready cfg_data     | sink
// One sample per cycle while the output register is empty or taken; 3 front stages, 16 cells, 1 output.
// The chain of 16 square-root cells decides one magnitude bit per cell.
// The whole pipeline advances when the output register is empty or taken.
// Reset clears all valid bits and sets alpha to 1.0; cfg_ready is always high.
module isrlu_activation #(
	parameter int DATA_WIDTH = isrlu_pkg::DATA_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [DATA_WIDTH-1:0]        x,
	input  logic                                last_in,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [DATA_WIDTH-1:0]        y,
	output logic                                last_out,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [isrlu_pkg::ALPHA_W-1:0]       cfg_data
);
	import isrlu_pkg::*;

	localparam int WW = 2 * DATA_WIDTH + 50;
	localparam int RW = MAG_BITS;

	logic                          en;
	logic [ALPHA_W-1:0]            alpha_q;
	ctl_t                          ctl_in;
	ctl_t                          ctl_c [MAG_BITS+1];
	logic signed [DATA_WIDTH-1:0]  x_c   [MAG_BITS+1];
	logic [WW-1:0]                 e_c   [MAG_BITS+1];
	logic [WW-1:0]                 r_c   [MAG_BITS+1];
	logic [WW-1:0]                 em_c  [MAG_BITS+1];
	logic [MAG_BITS-1:0]           m_c   [MAG_BITS+1];
	logic [RW-1:0]                 rnd;
	logic [DATA_WIDTH-1:0]         mag;
	logic                          vld_q, last_q;
	logic signed [DATA_WIDTH-1:0]  y_q;

	assign en        = ~vld_q | out_ready;
	assign in_ready  = en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			alpha_q <= ALPHA_RESET;
		else if (cfg_valid)
			alpha_q <= cfg_data;
	end

	always_comb begin
		ctl_in      = '0;
		ctl_in.vld  = in_valid;
		ctl_in.last = last_in;
	end

	isrlu_pre #(.DATA_WIDTH(DATA_WIDTH), .WW(WW)) u_pre (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.ctl_in  (ctl_in),
		.x_in    (x),
		.alpha   (alpha_q),
		.ctl_out (ctl_c[0]),
		.x_out   (x_c[0]),
		.e_out   (e_c[0]),
		.r_out   (r_c[0])
	);

	assign em_c[0] = '0;
	assign m_c[0]  = '0;

	for (genvar i = 0; i < MAG_BITS; i++) begin : g_cell
		isrlu_cell #(.DATA_WIDTH(DATA_WIDTH), .WW(WW), .BIT(MAG_BITS - 1 - i)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.ctl_in  (ctl_c[i]),
			.x_in    (x_c[i]),
			.e_in    (e_c[i]),
			.r_in    (r_c[i]),
			.em_in   (em_c[i]),
			.m_in    (m_c[i]),
			.ctl_out (ctl_c[i+1]),
			.x_out   (x_c[i+1]),
			.e_out   (e_c[i+1]),
			.r_out   (r_c[i+1]),
			.em_out  (em_c[i+1]),
			.m_out   (m_c[i+1])
		);
	end

	// round half up on the extra fraction bit, then clamp to the negative limit
	always_comb begin
		logic [RW:0] sum;
		sum = (RW + 1)'(m_c[MAG_BITS]) + (RW + 1)'(1);
		rnd = sum[RW:1];
		if ((DATA_WIDTH - 1) < RW && (RW + 1)'(rnd) > ((RW + 1)'(1) << (DATA_WIDTH - 1)))
			mag = DATA_WIDTH'(1) << (DATA_WIDTH - 1);
		else
			mag = DATA_WIDTH'(rnd);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= 1'b0;
		else if (en)
			vld_q <= ctl_c[MAG_BITS].vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			last_q <= ctl_c[MAG_BITS].last;
			y_q    <= ctl_c[MAG_BITS].byp ? x_c[MAG_BITS] : DATA_WIDTH'(-mag);
		end
	end

	assign out_valid = vld_q;
	assign y         = y_q;
	assign last_out  = last_q;
endmodule
